// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. In synthesis they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/frle_pkg.sv -----
package frle_pkg;

	// Fixed field widths.
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned GAIN_W  = 31;
	localparam int unsigned STEP_W  = 17;
	localparam int unsigned CIDX_W  = 3;
	localparam int unsigned CDATA_W = 31;

	// Register indexes on the configuration port.
	localparam logic [CIDX_W-1:0] CFG_ALLOC_MODE   = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_FFWD_GAIN    = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_OBS_GAIN_ONE = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_OBS_GAIN_TWO = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_STEP_SCALE   = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_RATE_LIMIT   = 3'd5;

	// Reset values of the registers.
	localparam logic              RST_ALLOC_MODE = 1'b1;
	localparam logic [GAIN_W-1:0] RST_GAIN       = 31'd65536;
	localparam logic [STEP_W-1:0] RST_STEP_SCALE = 17'd655;

	// Width of the step counter.
	localparam int unsigned STEP_W_CNT = 3;

	// ALU operand A.
	typedef enum logic [2:0] {
		A_RA, A_RR, A_XA, A_XD, A_T, A_ZERO
	} asel_t;

	// ALU operand B.
	typedef enum logic [1:0] {
		B_MA, B_XA, B_PRD, B_V
	} bsel_t;

	// ALU destination register.
	typedef enum logic [2:0] {
		D_T, D_U, D_E, D_V, D_XA, D_XD
	} dsel_t;

	// Multiplier value operand.
	typedef enum logic [1:0] {
		M_T, M_E, M_U
	} msel_t;

	// Multiplier gain operand.
	typedef enum logic [1:0] {
		G_FFWD, G_ONE, G_TWO, G_STEP
	} gsel_t;

	typedef struct packed {
		asel_t asel;
		bsel_t bsel;
		logic  sub;
		dsel_t dsel;
		logic  mul_en;
		msel_t msel;
		gsel_t gsel;
		logic  fin;
	} uword_t;

	// Control store. PRD is the scaled and saturated product registered in the
	// step before.
	function automatic uword_t ucode(input logic [STEP_W_CNT-1:0] step);
		uword_t w;
		w = '{asel: A_ZERO, bsel: B_PRD, sub: 1'b0, dsel: D_T,
			mul_en: 1'b0, msel: M_T, gsel: G_FFWD, fin: 1'b0};
		case (step)
			3'd0: begin // tracking error
				w.asel = A_RA; w.bsel = B_MA; w.sub = 1'b1; w.dsel = D_T;
			end
			3'd1: begin // observer error, feedforward product
				w.asel = A_RA; w.bsel = B_XA; w.sub = 1'b1; w.dsel = D_E;
				w.mul_en = 1'b1; w.msel = M_T; w.gsel = G_FFWD;
			end
			3'd2: begin // virtual law, first gain product
				w.asel = A_RR; w.bsel = B_PRD; w.dsel = D_V;
				w.mul_en = 1'b1; w.msel = M_E; w.gsel = G_ONE;
			end
			3'd3: begin // disturbance plus first gain term
				w.asel = A_XD; w.bsel = B_PRD; w.dsel = D_T;
			end
			3'd4: begin // add virtual law, second gain product
				w.asel = A_T; w.bsel = B_V; w.dsel = D_T;
				w.mul_en = 1'b1; w.msel = M_E; w.gsel = G_TWO;
			end
			3'd5: begin // hold second gain term, scale angle increment
				w.asel = A_ZERO; w.bsel = B_PRD; w.dsel = D_U;
				w.mul_en = 1'b1; w.msel = M_T; w.gsel = G_STEP;
			end
			3'd6: begin // angle update, scale disturbance increment
				w.asel = A_XA; w.bsel = B_PRD; w.dsel = D_XA;
				w.mul_en = 1'b1; w.msel = M_U; w.gsel = G_STEP;
			end
			3'd7: begin // disturbance update and result
				w.asel = A_XD; w.bsel = B_PRD; w.dsel = D_XD; w.fin = 1'b1;
			end
			default: begin
				w.fin = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/ffwd_rate_law_with_eso.sv -----
// Channel  Direction  Ports                      Payload (lowest bits first)
// s        in         s_tvalid s_tready s_tdata  ref_angle, ref_rate, measured_angle
// m        out        m_tvalid m_tready m_tdata  drive_rate, virtual_law, est_angle,
//                     m_tuser                    est_disturbance; tuser: limited
// cfg      in         cfg_we cfg_index cfg_wdata register write, no read-back
//
// Each item runs through an eight-step microprogram on the single shared
// multiplier and the single saturating adder. The next item is accepted
// in the cycle of the final step. A finished result sits in the output
// register; when that register is still full at the final step, the
// sequencer holds there until the result is taken. Reset clears the
// observer state, restores the register defaults and leaves the sequencer
// idle.
`include "assert_macros.svh"

module ffwd_rate_law_with_eso #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// ref_angle [31:0], ref_rate [63:32], measured_angle [95:64]
	input  logic [3*frle_pkg::VAL_W-1:0]      s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// drive_rate [31:0], virtual_law [63:32], est_angle [95:64],
	// est_disturbance [127:96]
	output logic [4*frle_pkg::VAL_W-1:0]      m_tdata,
	// limited [0]
	output logic                              m_tuser,
	input  logic                              cfg_we,
	input  logic [frle_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [frle_pkg::CDATA_W-1:0]      cfg_wdata
);

	// All internal sums and products saturate to this width, never wider
	// than the fields themselves.
	localparam int SAT_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > SAT_HI) begin
			r = SAT_HI;
		end else if (v < SAT_LO) begin
			r = SAT_LO;
		end
		return r[31:0];
	endfunction

	// Configuration registers.
	logic                          alloc_mode_q;
	logic [frle_pkg::GAIN_W-1:0]   ffwd_gain_q;
	logic [frle_pkg::GAIN_W-1:0]   obs_gain_one_q;
	logic [frle_pkg::GAIN_W-1:0]   obs_gain_two_q;
	logic [frle_pkg::STEP_W-1:0]   step_scale_q;
	logic [frle_pkg::GAIN_W-1:0]   rate_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_mode_q   <= frle_pkg::RST_ALLOC_MODE;
			ffwd_gain_q    <= frle_pkg::RST_GAIN;
			obs_gain_one_q <= frle_pkg::RST_GAIN;
			obs_gain_two_q <= frle_pkg::RST_GAIN;
			step_scale_q   <= frle_pkg::RST_STEP_SCALE;
			rate_limit_q   <= frle_pkg::RST_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				frle_pkg::CFG_ALLOC_MODE:   alloc_mode_q   <= cfg_wdata[0];
				frle_pkg::CFG_FFWD_GAIN:    ffwd_gain_q    <= cfg_wdata;
				frle_pkg::CFG_OBS_GAIN_ONE: obs_gain_one_q <= cfg_wdata;
				frle_pkg::CFG_OBS_GAIN_TWO: obs_gain_two_q <= cfg_wdata;
				frle_pkg::CFG_STEP_SCALE:   step_scale_q   <= cfg_wdata[frle_pkg::STEP_W-1:0];
				frle_pkg::CFG_RATE_LIMIT:   rate_limit_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer: a busy flag and a step counter address the control store.
	logic                                busy_q;
	logic [frle_pkg::STEP_W_CNT-1:0]     step_q;
	frle_pkg::uword_t                    uw;
	logic                                out_valid_q;
	logic                                adv;
	logic                                fin_adv;
	logic                                in_acc;

	assign uw = frle_pkg::ucode(step_q);

	// Every datapath write is gated by adv, so a held final step repeats nothing.
	assign adv      = busy_q && !(uw.fin && out_valid_q && !m_tready);
	assign fin_adv  = adv && uw.fin;
	assign s_tready = !busy_q || fin_adv;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (fin_adv) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (adv) begin
			step_q <= step_q + 3'd1;
		end
	end

	// Input item registers.
	logic signed [31:0] ra_q, rr_q, ma_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ra_q <= s_tdata[31:0];
			rr_q <= s_tdata[63:32];
			ma_q <= s_tdata[95:64];
		end
	end

	// Datapath registers: scratch values, virtual law and observer state.
	logic signed [31:0] t_q, u_q, e_q, v_q;
	logic signed [31:0] xa_q, xd_q;
	logic signed [63:0] prod_q;

	logic signed [31:0] a_op, b_op, prd, alu_res;
	logic signed [32:0] sum;
	logic signed [31:0] m_op, g_op;
	logic signed [63:0] mul_res;

	// Product scaled back to Q16.16; the arithmetic shift rounds toward minus
	// infinity.
	assign prd = sat(prod_q >>> FRAC_BITS);

	always_comb begin
		case (uw.asel)
			frle_pkg::A_RA:   a_op = ra_q;
			frle_pkg::A_RR:   a_op = rr_q;
			frle_pkg::A_XA:   a_op = xa_q;
			frle_pkg::A_XD:   a_op = xd_q;
			frle_pkg::A_T:    a_op = t_q;
			frle_pkg::A_ZERO: a_op = '0;
			default:          a_op = '0;
		endcase
		case (uw.bsel)
			frle_pkg::B_MA:  b_op = ma_q;
			frle_pkg::B_XA:  b_op = xa_q;
			frle_pkg::B_PRD: b_op = prd;
			frle_pkg::B_V:   b_op = v_q;
			default:         b_op = '0;
		endcase
		case (uw.msel)
			frle_pkg::M_T: m_op = t_q;
			frle_pkg::M_E: m_op = e_q;
			frle_pkg::M_U: m_op = u_q;
			default:       m_op = '0;
		endcase
		case (uw.gsel)
			frle_pkg::G_FFWD: g_op = {1'b0, ffwd_gain_q};
			frle_pkg::G_ONE:  g_op = {1'b0, obs_gain_one_q};
			frle_pkg::G_TWO:  g_op = {1'b0, obs_gain_two_q};
			frle_pkg::G_STEP: g_op = {15'd0, step_scale_q};
			default:          g_op = '0;
		endcase
	end

	assign sum     = uw.sub ? ({a_op[31], a_op} - {b_op[31], b_op})
	                        : ({a_op[31], a_op} + {b_op[31], b_op});
	assign alu_res = sat({{31{sum[32]}}, sum});
	assign mul_res = $signed({{32{m_op[31]}}, m_op}) * $signed({{32{g_op[31]}}, g_op});

	always_ff @(posedge clk) begin
		if (adv) begin
			case (uw.dsel)
				frle_pkg::D_T: t_q <= alu_res;
				frle_pkg::D_U: u_q <= alu_res;
				frle_pkg::D_E: e_q <= alu_res;
				frle_pkg::D_V: v_q <= alu_res;
				default: ;
			endcase
			if (uw.mul_en) begin
				prod_q <= mul_res;
			end
		end
	end

	// The observer state is the only datapath state that reset must clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xa_q <= '0;
			xd_q <= '0;
		end else if (adv) begin
			if (uw.dsel == frle_pkg::D_XA) begin
				xa_q <= alu_res;
			end
			if (uw.dsel == frle_pkg::D_XD) begin
				xd_q <= alu_res;
			end
		end
	end

	// Drive selection and inclusive symmetric clamp, evaluated at the final step.
	logic signed [31:0] drive_sel, lim_pos, lim_neg, drive_cl;
	logic               clamp_hit;

	assign drive_sel = alloc_mode_q ? rr_q : v_q;
	assign lim_pos   = {1'b0, rate_limit_q};
	assign lim_neg   = -lim_pos;

	always_comb begin
		drive_cl  = drive_sel;
		clamp_hit = 1'b0;
		if (drive_sel > lim_pos) begin
			drive_cl  = lim_pos;
			clamp_hit = 1'b1;
		end else if (drive_sel < lim_neg) begin
			drive_cl  = lim_neg;
			clamp_hit = 1'b1;
		end
	end

	// Output register: holds one finished result while the next item runs.
	logic [4*frle_pkg::VAL_W-1:0] out_data_q;
	logic                         out_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_adv) begin
			out_data_q <= {alu_res, xa_q, v_q, drive_cl};
			out_lim_q  <= clamp_hit;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_lim_q;

	`CHK_NEXT(a_start, clk, arst_n, in_acc, busy_q && step_q == '0, "item did not start")
	`CHK_SAME(a_fill, clk, arst_n, $rose(out_valid_q), $past(busy_q && uw.fin), "early result")
	`CHK_NEXT(a_hold, clk, arst_n, busy_q && !adv, $stable(xd_q) && $stable(xa_q), "state moved")
	`CHK_SAME(a_cnt, clk, arst_n, !busy_q, step_q == '0, "step counter running while idle")

endmodule
